// ----- rtl/core/spe2d_pkg.sv -----
// Shared types and constants of the 2-D sinusoidal position encoder.
// Holds the item packet that moves down the cell chain, the fixed-point
// constants and the reciprocal tables used by the series cells.
package spe2d_pkg;

  localparam int IDX_W    = 10;
  localparam int FEAT_W   = 8;
  localparam int SIZE_W   = 11;
  localparam int NF_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] MAX_GRID   = 11'd1024;
  localparam logic [NF_W-1:0]   MAX_FEATS  = 9'd256;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd64;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd64;
  localparam logic [NF_W-1:0]   RST_FEATS  = 9'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATS       = 2'd2;

  localparam logic [35:0] LOG2_TENK_Q32 = 36'd57070290109;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

  localparam int E_STEPS     = 36;
  localparam int PH_STEPS    = 33;
  localparam int EXP_TERMS   = 14;
  localparam int SIN_TERMS   = 8;
  localparam int RECIP_SHIFT = 42;

  // One restoring division lane: partial remainder, dividend bits still to
  // shift in (MSB first) and the quotient built so far.
  typedef struct packed {
    logic [10:0] rem;
    logic [43:0] num;
    logic [35:0] quo;
  } div_t;

  // One series lane: current term, the factor applied per term, running sum.
  typedef struct packed {
    logic [33:0]        term;
    logic [31:0]        mul;
    logic signed [35:0] sum;
  } ser_t;

  // Lane 0 carries the row axis, lane 1 the column axis.
  typedef struct packed {
    logic             invalid;
    logic             odd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [3:0]       n;
    logic [30:0]      freq;
    logic [1:0]       neg;
    div_t [1:0]       dv;
    ser_t [1:0]       sr;
  } pkt_t;

  // ceil(2^42 / k) for the exp series divisors k = 1..14.
  localparam logic [42:0] EXP_RECIP [EXP_TERMS] = '{
    43'(((64'd1 << 42) + 64'd0)  / 64'd1),
    43'(((64'd1 << 42) + 64'd1)  / 64'd2),
    43'(((64'd1 << 42) + 64'd2)  / 64'd3),
    43'(((64'd1 << 42) + 64'd3)  / 64'd4),
    43'(((64'd1 << 42) + 64'd4)  / 64'd5),
    43'(((64'd1 << 42) + 64'd5)  / 64'd6),
    43'(((64'd1 << 42) + 64'd6)  / 64'd7),
    43'(((64'd1 << 42) + 64'd7)  / 64'd8),
    43'(((64'd1 << 42) + 64'd8)  / 64'd9),
    43'(((64'd1 << 42) + 64'd9)  / 64'd10),
    43'(((64'd1 << 42) + 64'd10) / 64'd11),
    43'(((64'd1 << 42) + 64'd11) / 64'd12),
    43'(((64'd1 << 42) + 64'd12) / 64'd13),
    43'(((64'd1 << 42) + 64'd13) / 64'd14)
  };

  // ceil(2^42 / (2k(2k+1))) for the sine series, k = 1..8.
  localparam logic [42:0] SIN_RECIP [SIN_TERMS] = '{
    43'(((64'd1 << 42) + 64'd5)   / 64'd6),
    43'(((64'd1 << 42) + 64'd19)  / 64'd20),
    43'(((64'd1 << 42) + 64'd41)  / 64'd42),
    43'(((64'd1 << 42) + 64'd71)  / 64'd72),
    43'(((64'd1 << 42) + 64'd109) / 64'd110),
    43'(((64'd1 << 42) + 64'd155) / 64'd156),
    43'(((64'd1 << 42) + 64'd209) / 64'd210),
    43'(((64'd1 << 42) + 64'd271) / 64'd272)
  };

endpackage

// ----- rtl/core/spe2d_div_cell.sv -----
// One restoring division step on both lanes of the item packet.
// Depends on spe2d_pkg for the packet type.
module spe2d_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  spe2d_pkg::pkt_t             in_pkt,
  input  logic [1:0][10:0]            divisor,
  output logic                        out_vld,
  output spe2d_pkg::pkt_t             out_pkt
);

  logic            vld_r;
  spe2d_pkg::pkt_t pkt_r;
  spe2d_pkg::pkt_t pkt_nxt;

  always_comb begin
    logic [11:0] rem2;
    logic        ge;
    pkt_nxt = in_pkt;
    for (int l = 0; l < 2; l++) begin
      rem2 = {in_pkt.dv[l].rem, in_pkt.dv[l].num[43]};
      ge   = rem2 >= {1'b0, divisor[l]};
      pkt_nxt.dv[l].rem = ge ? 11'(rem2 - {1'b0, divisor[l]}) : rem2[10:0];
      pkt_nxt.dv[l].num = {in_pkt.dv[l].num[42:0], 1'b0};
      pkt_nxt.dv[l].quo = {in_pkt.dv[l].quo[34:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_pkt = pkt_r;

endmodule

// ----- rtl/core/spe2d_series_cell.sv -----
// One term of a power series on both lanes: multiply by the lane factor,
// then divide by the term's constant through its reciprocal and accumulate.
// Depends on spe2d_pkg for the packet type and the reciprocal shift.
module spe2d_series_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  spe2d_pkg::pkt_t  in_pkt,
  input  logic [42:0]      recip,
  input  logic             sub,
  output logic             out_vld,
  output spe2d_pkg::pkt_t  out_pkt
);

  logic            a_vld_r;
  logic            b_vld_r;
  spe2d_pkg::pkt_t a_r;
  spe2d_pkg::pkt_t b_r;
  spe2d_pkg::pkt_t a_nxt;
  spe2d_pkg::pkt_t b_nxt;

  always_comb begin
    a_nxt = in_pkt;
    for (int l = 0; l < 2; l++) begin
      a_nxt.sr[l].term = 34'((66'(in_pkt.sr[l].term) * 66'(in_pkt.sr[l].mul)) >> 30);
    end
  end

  // The reciprocal is wide enough that the product gives the exact quotient.
  always_comb begin
    logic [34:0] q;
    b_nxt = a_r;
    for (int l = 0; l < 2; l++) begin
      q = 35'((77'(a_r.sr[l].term) * 77'(recip)) >> spe2d_pkg::RECIP_SHIFT);
      b_nxt.sr[l].term = 34'(q);
      b_nxt.sr[l].sum  = sub ? a_r.sr[l].sum - $signed({1'b0, q})
                             : a_r.sr[l].sum + $signed({1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign out_vld = b_vld_r;
  assign out_pkt = b_r;

endmodule

// ----- rtl/core/sinusoidal_position_encoding_2d_top.sv -----
// 2-D sinusoidal position encoder: row/column/feature in, Q2.14 sine or cosine
// values for both axes out. Depends on spe2d_pkg, spe2d_div_cell, spe2d_series_cell.
//
// The block takes one request per clock while in_tready is high (it drops while the
// skid stage holds a result), and returns results in order. The chain of cells is a
// 36-step divider for the frequency exponent, a 14-term exp2 series, a 33-step
// divider for the row and column phases, and an 8-term sine series, plus the entry,
// setup, frequency, fold and output stages. An output register with a one-deep
// skid stage lets requests keep entering while a result waits to be taken.
// Configuration writes are accepted at any time but must only happen while no
// request is in flight.
module sinusoidal_position_encoding_2d_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index[9:0], col_index[19:10], feature_index[27:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // y_value[15:0], x_value[31:16]
  output logic        out_tuser   // invalid
);

  localparam int NE = spe2d_pkg::E_STEPS;
  localparam int NX = spe2d_pkg::EXP_TERMS;
  localparam int NP = spe2d_pkg::PH_STEPS;
  localparam int NS = spe2d_pkg::SIN_TERMS;

  // ---------------- configuration registers ----------------
  logic [10:0] grid_height_r;
  logic [10:0] grid_width_r;
  logic [8:0]  feats_r;
  logic [10:0] h_sat;
  logic [10:0] w_sat;
  logic [8:0]  nf_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_height_r <= spe2d_pkg::RST_HEIGHT;
      grid_width_r  <= spe2d_pkg::RST_WIDTH;
      feats_r       <= spe2d_pkg::RST_FEATS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spe2d_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        spe2d_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        spe2d_pkg::CFG_FEATS:       feats_r       <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign h_sat  = (grid_height_r > spe2d_pkg::MAX_GRID) ? spe2d_pkg::MAX_GRID : grid_height_r;
  assign w_sat  = (grid_width_r > spe2d_pkg::MAX_GRID) ? spe2d_pkg::MAX_GRID : grid_width_r;
  assign nf_sat = (feats_r > spe2d_pkg::MAX_FEATS) ? spe2d_pkg::MAX_FEATS : feats_r;

  // ---------------- flow control ----------------
  logic en;
  logic skid_vld_r;
  logic out_vld_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // ---------------- entry stage ----------------
  spe2d_pkg::pkt_t e_pkt [NE+1];
  logic [NE:0]     e_vld;
  spe2d_pkg::pkt_t s0_nxt;
  spe2d_pkg::pkt_t s0_r;
  logic            s0_vld_r;

  always_comb begin
    logic [9:0]  row;
    logic [9:0]  col;
    logic [7:0]  feat;
    logic [43:0] numer;
    row  = in_tdata[9:0];
    col  = in_tdata[19:10];
    feat = in_tdata[27:20];
    // 2p * log2(10000) in Q32; its top bits already form the first remainder.
    numer = 44'(44'({feat[7:1], 1'b0}) * 44'(spe2d_pkg::LOG2_TENK_Q32));
    s0_nxt         = '0;
    s0_nxt.invalid = ({1'b0, row} >= h_sat) || ({1'b0, col} >= w_sat)
                     || ({1'b0, feat} >= nf_sat);
    s0_nxt.odd     = feat[0];
    s0_nxt.row     = row;
    s0_nxt.col     = col;
    for (int l = 0; l < 2; l++) begin
      s0_nxt.dv[l].rem = {3'b0, numer[43:36]};
      s0_nxt.dv[l].num = {numer[35:0], 8'b0};
      s0_nxt.dv[l].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  assign e_pkt[0] = s0_r;
  assign e_vld[0] = s0_vld_r;

  // ---------------- exponent divider ----------------
  logic [1:0][10:0] e_div;
  assign e_div = {{2'b0, nf_sat}, {2'b0, nf_sat}};

  for (genvar i = 0; i < NE; i++) begin : g_ediv
    spe2d_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (e_vld[i]),
      .in_pkt  (e_pkt[i]),
      .divisor (e_div),
      .out_vld (e_vld[i+1]),
      .out_pkt (e_pkt[i+1])
    );
  end

  // ---------------- exp2 series setup ----------------
  spe2d_pkg::pkt_t x_pkt [NX+1];
  logic [NX:0]     x_vld;
  spe2d_pkg::pkt_t x0_nxt;
  spe2d_pkg::pkt_t x0_r;
  logic            x0_vld_r;

  always_comb begin
    logic [35:0] e;
    logic [29:0] xarg;
    e    = e_pkt[NE].dv[0].quo;
    xarg = 30'((60'(e[31:2]) * 60'(spe2d_pkg::LN2_Q30)) >> 30);
    x0_nxt   = e_pkt[NE];
    x0_nxt.n = e[35:32];
    for (int l = 0; l < 2; l++) begin
      x0_nxt.sr[l].term = 34'(spe2d_pkg::ONE_Q30);
      x0_nxt.sr[l].mul  = 32'(xarg);
      x0_nxt.sr[l].sum  = 36'(spe2d_pkg::ONE_Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_vld_r <= 1'b0;
    end else if (en) begin
      x0_vld_r <= e_vld[NE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= x0_nxt;
    end
  end

  assign x_pkt[0] = x0_r;
  assign x_vld[0] = x0_vld_r;

  for (genvar k = 0; k < NX; k++) begin : g_exp
    spe2d_series_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (x_vld[k]),
      .in_pkt  (x_pkt[k]),
      .recip   (spe2d_pkg::EXP_RECIP[k]),
      .sub     (((k + 1) % 2) == 1),
      .out_vld (x_vld[k+1]),
      .out_pkt (x_pkt[k+1])
    );
  end

  // ---------------- frequency and phase numerators ----------------
  spe2d_pkg::pkt_t f1_nxt;
  spe2d_pkg::pkt_t f1_r;
  logic            f1_vld_r;
  spe2d_pkg::pkt_t f2_nxt;
  spe2d_pkg::pkt_t f2_r;
  logic            f2_vld_r;

  always_comb begin
    logic signed [35:0] s;
    s = x_pkt[NX].sr[0].sum;
    if (s < 0) begin
      s = '0;
    end
    f1_nxt      = x_pkt[NX];
    f1_nxt.freq = 31'($unsigned(s) >> x_pkt[NX].n);
  end

  always_comb begin
    logic [10:0] idx1;
    logic [42:0] numer;
    f2_nxt = f1_r;
    for (int l = 0; l < 2; l++) begin
      idx1  = (l == 0) ? 11'({1'b0, f1_r.row}) + 11'd1 : 11'({1'b0, f1_r.col}) + 11'd1;
      numer = 43'((43'(idx1) * 43'(f1_r.freq)) << 2);
      f2_nxt.dv[l].rem = {1'b0, numer[42:33]};
      f2_nxt.dv[l].num = {numer[32:0], 11'b0};
      f2_nxt.dv[l].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= x_vld[NX];
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  // ---------------- phase divider ----------------
  spe2d_pkg::pkt_t p_pkt [NP+1];
  logic [NP:0]     p_vld;
  logic [1:0][10:0] p_div;

  assign p_pkt[0] = f2_r;
  assign p_vld[0] = f2_vld_r;
  assign p_div    = {w_sat, h_sat};

  for (genvar i = 0; i < NP; i++) begin : g_pdiv
    spe2d_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (p_vld[i]),
      .in_pkt  (p_pkt[i]),
      .divisor (p_div),
      .out_vld (p_vld[i+1]),
      .out_pkt (p_pkt[i+1])
    );
  end

  // ---------------- quadrant fold and sine setup ----------------
  spe2d_pkg::pkt_t q0_nxt;
  spe2d_pkg::pkt_t q0_r;
  spe2d_pkg::pkt_t q1_nxt;
  spe2d_pkg::pkt_t q1_r;
  spe2d_pkg::pkt_t q2_nxt;
  spe2d_pkg::pkt_t q2_r;
  logic [2:0]      q_vld_r;

  // The cosine is the sine a quarter turn later.
  always_comb begin
    logic [31:0] ph;
    logic [30:0] u;
    q0_nxt = p_pkt[NP];
    for (int l = 0; l < 2; l++) begin
      ph = p_pkt[NP].dv[l].quo[31:0] + (p_pkt[NP].odd ? 32'h4000_0000 : 32'h0);
      u  = {1'b0, ph[29:0]};
      if (ph[30]) begin
        u = spe2d_pkg::ONE_Q30 - u;
      end
      q0_nxt.neg[l]     = ph[31];
      q0_nxt.sr[l].term = 34'(u);
    end
  end

  always_comb begin
    q1_nxt = q0_r;
    for (int l = 0; l < 2; l++) begin
      q1_nxt.sr[l].term = 34'((62'(q0_r.sr[l].term[30:0]) * 62'(spe2d_pkg::HALF_PI_Q30)) >> 30);
    end
  end

  always_comb begin
    q2_nxt = q1_r;
    for (int l = 0; l < 2; l++) begin
      q2_nxt.sr[l].mul = 32'((62'(q1_r.sr[l].term[30:0]) * 62'(q1_r.sr[l].term[30:0])) >> 30);
      q2_nxt.sr[l].sum = 36'(q1_r.sr[l].term[30:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= '0;
    end else if (en) begin
      q_vld_r <= {q_vld_r[1:0], p_vld[NP]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r <= q0_nxt;
      q1_r <= q1_nxt;
      q2_r <= q2_nxt;
    end
  end

  // ---------------- sine series ----------------
  spe2d_pkg::pkt_t s_pkt [NS+1];
  logic [NS:0]     s_vld;

  assign s_pkt[0] = q2_r;
  assign s_vld[0] = q_vld_r[2];

  for (genvar k = 0; k < NS; k++) begin : g_sin
    spe2d_series_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (s_vld[k]),
      .in_pkt  (s_pkt[k]),
      .recip   (spe2d_pkg::SIN_RECIP[k]),
      .sub     (((k + 1) % 2) == 1),
      .out_vld (s_vld[k+1]),
      .out_pkt (s_pkt[k+1])
    );
  end

  // ---------------- rounding and output buffer ----------------
  logic [31:0] res_data;
  logic        res_inv;
  logic [31:0] out_data_r;
  logic        out_inv_r;
  logic [31:0] skid_data_r;
  logic        skid_inv_r;

  always_comb begin
    logic [30:0] mag;
    logic [14:0] r;
    logic [15:0] v;
    res_inv  = s_pkt[NS].invalid;
    res_data = '0;
    for (int l = 0; l < 2; l++) begin
      mag = ($unsigned(s_pkt[NS].sr[l].sum) > 36'(spe2d_pkg::ONE_Q30))
            ? spe2d_pkg::ONE_Q30 : s_pkt[NS].sr[l].sum[30:0];
      r   = 15'((32'(mag) + 32'h8000) >> 16);
      v   = s_pkt[NS].neg[l] ? 16'(-{1'b0, r}) : {1'b0, r};
      if (res_inv) begin
        v = '0;
      end
      res_data[l*16 +: 16] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_tready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= s_vld[NS];
      end
    end else if (s_vld[NS] && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_data_r <= skid_data_r;
        out_inv_r  <= skid_inv_r;
      end else begin
        out_data_r <= res_data;
        out_inv_r  <= res_inv;
      end
    end else if (en) begin
      skid_data_r <= res_data;
      skid_inv_r  <= res_inv;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_inv_r;

  // ---------------- checks ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a result while the output register is empty");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'h0))
    else $error("invalid result carries nonzero values");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384
                    && $signed(out_tdata[15:0]) >= -16'sd16384
                    && $signed(out_tdata[31:16]) <= 16'sd16384
                    && $signed(out_tdata[31:16]) >= -16'sd16384))
    else $error("output value outside unit range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !skid_vld_r))
    else $error("result present right after reset");

endmodule

// ----- test/sinusoidal_position_encoding_2d_top_tb.sv -----
// Self-checking testbench for the 2-D sinusoidal position encoder.
// Depends on spe2d_pkg and sinusoidal_position_encoding_2d_top; predicts each
// result in fixed point and compares it, under random idling on both streams.
module sinusoidal_position_encoding_2d_top_tb;

  typedef struct {
    logic [15:0] y_value;
    logic [15:0] x_value;
    logic        invalid;
  } enc_result_t;

  localparam longint unsigned TENK_LOG2 = 64'd57070290109;
  localparam longint unsigned LN2_FX    = 64'd744261118;
  localparam longint unsigned HPI_FX    = 64'd1686629713;
  localparam longint unsigned UNIT_FX   = 64'd1073741824;
  localparam int              RUN_LIMIT = 600000;
  localparam int              LATENCY   = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  sinusoidal_position_encoding_2d_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Shadow copy of the three size registers.
  logic [10:0] height_reg;
  logic [10:0] width_reg;
  logic [8:0]  feats_reg;

  enc_result_t pending_results[$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_len;
  bit          hold_req;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic longint unsigned exp2_neg_frac(longint unsigned r32);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = ((r32 >> 2) * LN2_FX) >> 30;
    sum  = longint'(UNIT_FX);
    term = UNIT_FX;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * x) >> 30) / longint'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  function automatic logic [15:0] axis_encoding(longint unsigned idx, longint unsigned size,
                                                longint unsigned freq, bit odd);
    longint unsigned phase;
    logic [31:0]     ph;
    longint unsigned u, a, a2, term, sum, r;
    bit              neg;
    if (size == 0) return 16'd0;
    phase = (((idx + 1) * freq) << 2) / size;
    ph    = phase[31:0];
    if (odd) ph = ph + 32'h4000_0000;
    u = {34'd0, ph[29:0]};
    if (ph[30]) u = UNIT_FX - u;
    neg  = ph[31];
    a    = (u * HPI_FX) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    sum  = a;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum > UNIT_FX) sum = UNIT_FX;
    r = (sum + (64'd1 << 15)) >> 16;
    if (neg) r = 64'd0 - r;
    return r[15:0];
  endfunction

  function automatic enc_result_t encode_position(logic [9:0] row, logic [9:0] col,
                                                  logic [7:0] feat);
    enc_result_t     res;
    longint unsigned h, w, nf, e, n, freq;
    h  = (height_reg > 11'd1024) ? 1024 : height_reg;
    w  = (width_reg > 11'd1024) ? 1024 : width_reg;
    nf = (feats_reg > 9'd256) ? 256 : feats_reg;
    res.y_value = 16'd0;
    res.x_value = 16'd0;
    res.invalid = 1'b1;
    if (row >= h || col >= w || feat >= nf || nf == 0) return res;
    e = ((longint'(feat) >> 1) * 2 * TENK_LOG2) / nf;
    n = e >> 32;
    if (n > 62) n = 62;
    freq = exp2_neg_frac(e & 64'hFFFF_FFFF) >> n;
    res.y_value = axis_encoding(row, h, freq, feat[0]);
    res.x_value = axis_encoding(col, w, freq, feat[0]);
    res.invalid = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("Mismatch in %s at result %0d: got %0h, expected %0h", field, results_seen,
             got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    enc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[15:0], 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.y_value)
          report_mismatch("y_value", out_tdata[15:0], want.y_value);
        if (out_tdata[31:16] !== want.x_value)
          report_mismatch("x_value", out_tdata[31:16], want.x_value);
        if (out_tuser !== want.invalid)
          report_mismatch("invalid", {15'd0, out_tuser}, {15'd0, want.invalid});
      end
      results_seen++;
    end
  end

  // Entered and left at a falling edge.
  task automatic send_item(logic [9:0] row, logic [9:0] col, logic [7:0] feat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, feat, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(encode_position(row, col, feat));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Drops cfg_valid after each write and leaves the configuration channel idle before returning.
  task automatic write_register(logic [1:0] idx, logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spe2d_pkg::CFG_GRID_HEIGHT: height_reg = value;
      spe2d_pkg::CFG_GRID_WIDTH:  width_reg  = value;
      spe2d_pkg::CFG_FEATS:       feats_reg  = value[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sizes(logic [10:0] h, logic [10:0] w, logic [10:0] nf);
    wait_drained();
    write_register(spe2d_pkg::CFG_GRID_HEIGHT, h);
    write_register(spe2d_pkg::CFG_GRID_WIDTH, w);
    write_register(spe2d_pkg::CFG_FEATS, nf);
  endtask

  task automatic test_reset_defaults();
    send_item(10'd0, 10'd0, 8'd0);
    send_item(10'd0, 10'd0, 8'd1);
    send_item(10'd63, 10'd63, 8'd127);
    send_item(10'd63, 10'd0, 8'd126);
    send_item(10'd64, 10'd0, 8'd0);
    send_item(10'd0, 10'd64, 8'd0);
    send_item(10'd0, 10'd0, 8'd128);
    send_item(10'd1023, 10'd1023, 8'd255);
    send_item(10'd31, 10'd15, 8'd2);
    send_item(10'd15, 10'd31, 8'd3);
  endtask

  task automatic test_size_extremes();
    set_sizes(11'd1, 11'd1, 11'd1);
    send_item(10'd0, 10'd0, 8'd0);
    send_item(10'd0, 10'd0, 8'd1);
    send_item(10'd1, 10'd0, 8'd0);
    set_sizes(11'd1024, 11'd1024, 11'd256);
    send_item(10'd1023, 10'd1023, 8'd255);
    send_item(10'd1023, 10'd0, 8'd254);
    send_item(10'd511, 10'd512, 8'd129);
    // Values above the maximum saturate; the feature register keeps 9 bits.
    set_sizes(11'd2047, 11'd1500, 11'd2047);
    send_item(10'd1023, 10'd1023, 8'd255);
    send_item(10'd0, 10'd1023, 8'd0);
    set_sizes(11'd0, 11'd64, 11'd128);
    send_item(10'd0, 10'd0, 8'd0);
    set_sizes(11'd64, 11'd64, 11'd0);
    send_item(10'd0, 10'd0, 8'd0);
    // A write to the unused index must change nothing.
    set_sizes(11'd3, 11'd5, 11'd2);
    write_register(2'd3, 11'h7FF);
    send_item(10'd2, 10'd4, 8'd1);
    send_item(10'd3, 10'd4, 8'd1);
  endtask

  function automatic logic [10:0] pick_size(int top);
    int r;
    r = $urandom_range(99);
    if (r < 15) return 11'd1;
    if (r < 30) return 11'(top);
    if (r < 35) return 11'($urandom_range(2047));
    if (r < 70) return 11'($urandom_range(16, 1));
    return 11'($urandom_range(top, 1));
  endfunction

  task automatic send_random_items(int count);
    int h, w, nf;
    h  = (height_reg > 11'd1024) ? 1024 : height_reg;
    w  = (width_reg > 11'd1024) ? 1024 : width_reg;
    nf = (feats_reg > 9'd256) ? 256 : feats_reg;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80 && h > 0 && w > 0 && nf > 0)
        send_item(10'($urandom_range(h - 1)), 10'($urandom_range(w - 1)),
                  8'($urandom_range(nf - 1)));
      else
        send_item(10'($urandom), 10'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_phase(int sender_pct, int stall_pct, int count);
    send_idle_pct  = sender_pct;
    recv_stall_pct = stall_pct;
    for (int s = 0; s < 6; s++) begin
      set_sizes(pick_size(1024), pick_size(1024), pick_size(256));
      send_random_items(count / 6);
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_sizes(11'd1024, 11'd1024, 11'd256);
    hold_len = 400;
    hold_req = 1'b1;
    send_random_items(250);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    height_reg     = spe2d_pkg::RST_HEIGHT;
    width_reg      = spe2d_pkg::RST_WIDTH;
    feats_reg      = spe2d_pkg::RST_FEATS;
    mismatches     = 0;
    items_sent     = 0;
    results_seen   = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_size_extremes();
    test_random_phase(0, 0, 420);
    test_random_phase(85, 0, 420);
    test_random_phase(0, 85, 420);
    test_random_phase(29, 29, 420);
    test_output_backpressure();

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    $display("Sent %0d positions, checked %0d results across size extremes,", items_sent,
             results_seen);
    $display("out-of-range indices, idle and stall phases and a long output hold-off.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
